>>> sv/assert_macros.svh
// Assertion shorthands shared by the checker files.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked property, off while reset is high.
`define APSP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Same-cycle implication, off while reset is high.
`define APSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> sv/apsp_pkg.sv
// Shared types and constants for the all-pairs shortest-path unit.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package apsp_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int DIST_BITS_DEF = 24;

  localparam int CMD_BITS   = 2;
  localparam int NODE_BITS  = 6;
  localparam int EDGE_BITS  = 24;
  localparam int OUT_BITS   = 24;
  localparam int COUNT_BITS = 7;

  localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = 7'd64;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_EDGE1,
    S_EDGE2,
    S_READ,
    S_READ_WAIT,
    S_ROW,
    S_ROW_WAIT,
    S_COL,
    S_RESP
  } state_t;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_FILL,
    DP_EDGE,
    DP_LATCH_IK,
    DP_RELAX
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   capture;
    logic   respond;
    logic   rd_out;
    logic   in_range;
    logic   skip;
  } ctl_t;

endpackage

`default_nettype wire

>>> sv/apsp_ctrl.sv
// Controller: command FSM, loop counters k/i/j, clearing sweep, node_count register.
// Uses apsp_pkg; drives apsp_datapath through ctl_t and memory addresses.
`default_nettype none

module apsp_ctrl import apsp_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic [CMD_BITS-1:0]   command,
  input  wire logic [NODE_BITS-1:0]  node_a,
  input  wire logic [NODE_BITS-1:0]  node_b,
  input  wire logic                  cfg_valid,
  input  wire logic [COUNT_BITS-1:0] cfg_data,
  output      ctl_t                  ctl,
  output      logic [2*$clog2(MAX_NODES)-1:0] addr_a,
  output      logic [2*$clog2(MAX_NODES)-1:0] addr_b,
  output      logic [2*$clog2(MAX_NODES)-1:0] waddr
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int AW = 2 * NW;

  state_t state, state_next;
  cmd_t   cmd;

  logic [COUNT_BITS-1:0] node_count;
  logic [NW-1:0]         k, i, j;
  logic [NW-1:0]         last_q;
  logic [NW-1:0]         a_q, b_q;
  logic                  ok_q;
  logic [AW-1:0]         sweep_cnt;
  logic                  reply_q;

  logic [31:0]   a32, b32, nc32, lim32;
  logic          ok_now;
  logic          nc_zero;
  logic [NW-1:0] last_now;

  assign cmd      = cmd_t'(command);
  assign a32      = 32'(node_a);
  assign b32      = 32'(node_b);
  assign ok_now   = (a32 < 32'(MAX_NODES)) && (b32 < 32'(MAX_NODES));
  assign nc32     = 32'(node_count);
  assign nc_zero  = (node_count == '0);
  assign lim32    = (nc32 > 32'(MAX_NODES)) ? 32'(MAX_NODES) : nc32;
  assign last_now = NW'(lim32 - 32'd1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        if (sweep_cnt == '1) state_next = reply_q ? S_RESP : S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          unique case (cmd)
            CMD_CLEAR: state_next = S_SWEEP;
            CMD_EDGE:  state_next = ok_now ? S_EDGE1 : S_RESP;
            CMD_RUN:   state_next = nc_zero ? S_RESP : S_ROW;
            CMD_READ:  state_next = S_READ;
          endcase
        end
      end
      S_EDGE1:     state_next = S_EDGE2;
      S_EDGE2:     state_next = S_RESP;
      S_READ:      state_next = S_READ_WAIT;
      S_READ_WAIT: state_next = S_IDLE;
      S_ROW:       state_next = S_ROW_WAIT;
      S_ROW_WAIT:  state_next = S_COL;
      S_COL: begin
        if (j == last_q) begin
          if (i == last_q && k == last_q) state_next = S_RESP;
          else                            state_next = S_ROW;
        end
      end
      S_RESP:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // outputs to the datapath
  always_comb begin
    ctl    = '0;
    ctl.op = DP_IDLE;
    addr_a = {i, k};
    addr_b = {i, j};
    waddr  = sweep_cnt;
    busy   = (state != S_IDLE);
    unique case (state)
      S_SWEEP: ctl.op = DP_FILL;
      S_IDLE:  ctl.capture = start;
      S_EDGE1: begin
        ctl.op = DP_EDGE;
        waddr  = {a_q, b_q};
      end
      S_EDGE2: begin
        ctl.op = DP_EDGE;
        waddr  = {b_q, a_q};
      end
      S_READ:  addr_a = {a_q, b_q};
      S_READ_WAIT: begin
        ctl.respond  = 1'b1;
        ctl.rd_out   = 1'b1;
        ctl.in_range = ok_q;
      end
      S_ROW:      addr_a = {i, k};
      S_ROW_WAIT: ctl.op = DP_LATCH_IK;
      S_COL: begin
        ctl.op   = DP_RELAX;
        ctl.skip = (i == j);
        addr_a   = {k, j};
        addr_b   = {i, j};
      end
      S_RESP:  ctl.respond = 1'b1;
      default: ctl.op = DP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_cnt  <= '0;
      reply_q    <= 1'b0;
      node_count <= NODE_COUNT_RESET;
      k          <= '0;
      i          <= '0;
      j          <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) node_count <= cfg_data;

      if (state == S_SWEEP) sweep_cnt <= sweep_cnt + 1'b1;

      if (state == S_IDLE && start) begin
        k <= '0;
        i <= '0;
        j <= '0;
        if (cmd == CMD_CLEAR) begin
          sweep_cnt <= '0;
          reply_q   <= 1'b1;
        end
      end

      // walk j fastest, then i, then k
      if (state == S_COL) begin
        if (j == last_q) begin
          j <= '0;
          if (i == last_q) begin
            i <= '0;
            k <= k + 1'b1;
          end else begin
            i <= i + 1'b1;
          end
        end else begin
          j <= j + 1'b1;
        end
      end
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      a_q    <= a32[NW-1:0];
      b_q    <= b32[NW-1:0];
      ok_q   <= ok_now;
      last_q <= last_now;
    end
  end

endmodule

`default_nettype wire

>>> sv/apsp_datapath.sv
// Datapath: distance memory (one write, two registered reads), saturating
// relax adder, and the result register. Uses apsp_pkg; driven by apsp_ctrl.
`default_nettype none

module apsp_datapath import apsp_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int DIST_BITS = DIST_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ctl_t                 ctl,
  input  wire logic [2*$clog2(MAX_NODES)-1:0] addr_a,
  input  wire logic [2*$clog2(MAX_NODES)-1:0] addr_b,
  input  wire logic [2*$clog2(MAX_NODES)-1:0] waddr,
  input  wire logic [EDGE_BITS-1:0] edge_distance,
  output      logic                 done,
  output      logic [OUT_BITS-1:0]  distance,
  output      logic                 reachable
);

  localparam int AW    = 2 * $clog2(MAX_NODES);
  localparam int DEPTH = 1 << AW;
  localparam logic [DIST_BITS-1:0] INF    = '1;
  localparam logic [31:0]          INF32  = 32'(INF);
  localparam logic [31:0]          OUT_MAX32 = 32'(OUT_BITS'('1));

  logic [DIST_BITS-1:0] mem [DEPTH];

  logic [DIST_BITS-1:0] rd_a_q, rd_b_q;
  logic [DIST_BITS-1:0] ik_q;
  logic [DIST_BITS-1:0] edge_q;
  logic [AW-1:0]        wr_addr_q;
  logic                 relax_q;

  logic [31:0]          e32, rd32;
  logic [DIST_BITS-1:0] edge_clamp;
  logic [DIST_BITS:0]   sum;
  logic                 relax_we;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [DIST_BITS-1:0] mem_wd;
  logic [OUT_BITS-1:0]  rd_dist;
  logic                 rd_reach;

  // an edge at or above infinity is stored as unreachable
  assign e32        = 32'(edge_distance);
  assign edge_clamp = (e32 >= INF32) ? INF : e32[DIST_BITS-1:0];

  // d(i,k) + d(k,j); replace d(i,j) only on a strictly shorter finite sum
  assign sum      = {1'b0, ik_q} + {1'b0, rd_a_q};
  assign relax_we = relax_q && (ik_q != INF) && (rd_a_q != INF)
                    && (sum < {1'b0, rd_b_q});

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_addr_q;
    mem_wd = sum[DIST_BITS-1:0];
    priority if (ctl.op == DP_FILL) begin
      mem_we = 1'b1;
      mem_wa = waddr;
      mem_wd = INF;
    end else if (ctl.op == DP_EDGE) begin
      mem_we = 1'b1;
      mem_wa = waddr;
      mem_wd = edge_q;
    end else if (relax_we) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  always_comb begin
    rd32 = 32'(rd_a_q);
    if (!ctl.in_range || rd_a_q == INF) begin
      rd_dist  = '1;
      rd_reach = 1'b0;
    end else begin
      rd_dist  = (rd32 > OUT_MAX32) ? '1 : rd32[OUT_BITS-1:0];
      rd_reach = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relax_q <= 1'b0;
      done    <= 1'b0;
    end else begin
      relax_q <= (ctl.op == DP_RELAX) && !ctl.skip;
      done    <= ctl.respond;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_q <= addr_b;
    if (ctl.capture)             edge_q <= edge_clamp;
    if (ctl.op == DP_LATCH_IK)   ik_q   <= rd_a_q;
    if (ctl.respond) begin
      distance  <= ctl.rd_out ? rd_dist  : '0;
      reachable <= ctl.rd_out ? rd_reach : 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> sv/all_pairs_shortest_path_unit.sv
// All-pairs shortest-distance unit. A run relaxes over n = min(node_count, MAX_NODES)
// nodes, the single memory write port doing one relax step a cycle while it walks a
// row, with a pause to load d(i,k) before each row. One command at a time.
// done is high for one cycle, while distance and reachable hold until the next
// result; the receiver cannot stall.
// Reset: synchronous; busy stays high while the clearing pass fills every memory word.
`default_nettype none

module all_pairs_shortest_path_unit import apsp_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int DIST_BITS = DIST_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic [CMD_BITS-1:0]   command,
  input  wire logic [NODE_BITS-1:0]  node_a,
  input  wire logic [NODE_BITS-1:0]  node_b,
  input  wire logic [EDGE_BITS-1:0]  edge_distance,
  output      logic                  done,
  output      logic [OUT_BITS-1:0]   distance,
  output      logic                  reachable,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [COUNT_BITS-1:0] cfg_data
);

  localparam int AW = 2 * $clog2(MAX_NODES);

  ctl_t          ctl;
  logic [AW-1:0] addr_a, addr_b, waddr;

  assign cfg_ready = 1'b1;

  apsp_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .node_a    (node_a),
    .node_b    (node_b),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .waddr     (waddr)
  );

  apsp_datapath #(
    .MAX_NODES (MAX_NODES),
    .DIST_BITS (DIST_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .addr_a        (addr_a),
    .addr_b        (addr_b),
    .waddr         (waddr),
    .edge_distance (edge_distance),
    .done          (done),
    .distance      (distance),
    .reachable     (reachable)
  );

endmodule

`default_nettype wire

>>> sv/apsp_checker.sv
// Port-level checks on the all-pairs shortest-path unit, bound to the top level.
// Needs assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module apsp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [23:0] distance,
  input wire logic        reachable
);

  // an accepted word keeps the unit busy in the next cycle
  `APSP_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy, "busy not raised")

  // the unit never leaves idle on its own
  `APSP_ASSERT(a_idle_holds, clk, rst, (!busy && !start) |=> !busy, "busy without start")

  // every result is a single-cycle strobe shown with the unit idle
  `APSP_ASSERT(a_done_pulse, clk, rst, done |=> !done, "done held two cycles")
  `APSP_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "done while busy")

  // unreachable answers are all ones, other commands answer zero
  `APSP_ASSERT_IMPL(a_unreach, clk, rst, done && !reachable,
    distance == 24'hFFFFFF || distance == 24'h000000, "bad unreachable distance")

endmodule

bind all_pairs_shortest_path_unit apsp_checker u_apsp_checker (.*);

`default_nettype wire

>>> tb/tb_all_pairs_shortest_path_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the all-pairs shortest-path unit: a queue-fed command driver,
// a result monitor checked against a built-in distance table predictor, and a stall watchdog.
// Depends on apsp_pkg and all_pairs_shortest_path_unit.

module tb_all_pairs_shortest_path_unit;
  import apsp_pkg::*;

  localparam int PERIOD_HI = 4;
  localparam int PERIOD_LO = 4;
  localparam int RESET_CYCLES = 7;
  localparam int TARGET_CMDS = 550;
  localparam int IDLE_PCT = 11;
  // The limit must outlast a full 64-node relaxation, during which nothing moves.
  localparam int STALL_LIMIT = 1_100_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [DIST_BITS_DEF-1:0] UNREACHED = '1;
  localparam logic [OUT_BITS-1:0] OUT_CEILING = '1;

  typedef struct packed {
    cmd_t                  cmd;
    logic [NODE_BITS-1:0]  src;
    logic [NODE_BITS-1:0]  dst;
    logic [EDGE_BITS-1:0]  len;
  } path_cmd_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] path_len;
    logic                reach;
  } path_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [CMD_BITS-1:0] command = '0;
  logic [NODE_BITS-1:0] node_a = '0;
  logic [NODE_BITS-1:0] node_b = '0;
  logic [EDGE_BITS-1:0] edge_distance = '0;
  logic cfg_valid = 1'b0;
  logic [COUNT_BITS-1:0] cfg_data = '0;
  logic busy;
  logic done;
  logic [OUT_BITS-1:0] distance;
  logic reachable;
  logic cfg_ready;

  all_pairs_shortest_path_unit dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .node_a        (node_a),
    .node_b        (node_b),
    .edge_distance (edge_distance),
    .done          (done),
    .distance      (distance),
    .reachable     (reachable),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #PERIOD_LO clk = 1'b1;
    #PERIOD_HI clk = 1'b0;
  end

  // Predictor state: distance table and node count as the unit should hold them.
  logic [DIST_BITS_DEF-1:0] route_table [MAX_NODES_DEF][MAX_NODES_DEF];
  int node_limit;

  path_cmd_t    pending_cmds [$];
  path_answer_t expected_answers [$];
  path_cmd_t    held_cmd;
  int           cmds_queued = 0;
  int           words_taken = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;

  function automatic void clear_routes();
    for (int r = 0; r < MAX_NODES_DEF; r++)
      for (int c = 0; c < MAX_NODES_DEF; c++)
        route_table[r][c] = UNREACHED;
  endfunction

  function automatic logic [DIST_BITS_DEF-1:0] saturating_sum(
    input logic [DIST_BITS_DEF-1:0] x,
    input logic [DIST_BITS_DEF-1:0] y
  );
    logic [DIST_BITS_DEF:0] s;
    if (x == UNREACHED || y == UNREACHED) return UNREACHED;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, UNREACHED}) return UNREACHED;
    return s[DIST_BITS_DEF-1:0];
  endfunction

  function automatic void relax_routes();
    int lim;
    logic [DIST_BITS_DEF-1:0] s;
    lim = (node_limit > MAX_NODES_DEF) ? MAX_NODES_DEF : node_limit;
    for (int k = 0; k < lim; k++)
      for (int i = 0; i < lim; i++)
        for (int j = 0; j < lim; j++) begin
          if (i != j) begin
            s = saturating_sum(route_table[i][k], route_table[k][j]);
            if (s < route_table[i][j]) route_table[i][j] = s;
          end
        end
  endfunction

  function automatic void apply_command(input path_cmd_t w);
    path_answer_t ans;
    logic [DIST_BITS_DEF-1:0] d;
    ans = '0;
    case (w.cmd)
      CMD_CLEAR: clear_routes();
      CMD_EDGE: begin
        d = (w.len >= UNREACHED) ? UNREACHED : w.len;
        route_table[w.src][w.dst] = d;
        route_table[w.dst][w.src] = d;
      end
      CMD_RUN: relax_routes();
      default: begin
        d = route_table[w.src][w.dst];
        if (d == UNREACHED) begin
          ans.path_len = OUT_CEILING;
          ans.reach = 1'b0;
        end else begin
          ans.path_len = d;
          ans.reach = 1'b1;
        end
      end
    endcase
    expected_answers = {expected_answers, ans};
  endfunction

  // Command driver: hold start until the word is taken, then load the next one.
  always @(posedge clk) begin : drive_cmds
    logic slot_free;
    logic stall;
    if (rst) begin
      start <= 1'b0;
    end else begin
      slot_free = !start || !busy;
      if (start && !busy) begin
        apply_command(held_cmd);
        words_taken++;
      end
      stall = ($urandom_range(0, 99) < IDLE_PCT) && !(words_taken >= 150 && words_taken < 300);
      if (slot_free) begin
        if (pending_cmds.size() != 0 && !stall) begin
          held_cmd = pending_cmds.pop_front();
          start <= 1'b1;
          command <= held_cmd.cmd;
          node_a <= held_cmd.src;
          node_b <= held_cmd.dst;
          edge_distance <= held_cmd.len;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_answers
    path_answer_t want;
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result distance=%h reachable=%b",
                 $time, distance, reachable);
        mismatches++;
      end else begin
        want = expected_answers.pop_front();
        if (distance !== want.path_len) begin
          $display("%0t: distance mismatch expected=%h actual=%h",
                   $time, want.path_len, distance);
          mismatches++;
        end
        if (reachable !== want.reach) begin
          $display("%0t: reachable mismatch expected=%b actual=%b",
                   $time, want.reach, reachable);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles with no word moving on any channel.
  always @(posedge clk) begin
    if ((start && !busy) || done === 1'b1 || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("all_pairs_shortest_path_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_cmd(
    input cmd_t cmd,
    input logic [NODE_BITS-1:0] src,
    input logic [NODE_BITS-1:0] dst,
    input logic [EDGE_BITS-1:0] len
  );
    path_cmd_t w;
    w.cmd = cmd;
    w.src = src;
    w.dst = dst;
    w.len = len;
    pending_cmds = {pending_cmds, w};
    cmds_queued++;
  endfunction

  function automatic logic [NODE_BITS-1:0] any_node();
    return NODE_BITS'($urandom_range(0, MAX_NODES_DEF - 1));
  endfunction

  function automatic logic [EDGE_BITS-1:0] pick_length();
    logic [EDGE_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '1;
      1: v = EDGE_BITS'(24'hFFFFFF - $urandom_range(1, 300));
      2, 3: v = EDGE_BITS'($urandom());
      4: v = {1'b0, 23'($urandom())};
      default: v = EDGE_BITS'($urandom_range(0, 4095));
    endcase
    return v;
  endfunction

  // Optional clear, edges in a small node pool, one relaxation, then reads mostly in the pool.
  function automatic void queue_well_formed(input int span, input int pool_n);
    logic [NODE_BITS-1:0] pool [12];
    int edges;
    int reads;
    for (int p = 0; p < pool_n; p++) pool[p] = NODE_BITS'($urandom_range(0, span - 1));
    if ($urandom_range(0, 3) == 0) queue_cmd(CMD_CLEAR, any_node(), any_node(), pick_length());
    edges = $urandom_range(1, 2 * pool_n);
    repeat (edges)
      queue_cmd(CMD_EDGE, pool[$urandom_range(0, pool_n - 1)],
                pool[$urandom_range(0, pool_n - 1)], pick_length());
    queue_cmd(CMD_RUN, any_node(), any_node(), pick_length());
    reads = $urandom_range(3, 10);
    repeat (reads) begin
      if ($urandom_range(0, 4) == 0)
        queue_cmd(CMD_READ, any_node(), any_node(), pick_length());
      else
        queue_cmd(CMD_READ, pool[$urandom_range(0, pool_n - 1)],
                  pool[$urandom_range(0, pool_n - 1)], pick_length());
    end
  endfunction

  function automatic void queue_noise();
    int r;
    repeat ($urandom_range(6, 12)) begin
      r = $urandom_range(0, 9);
      if (r == 0) queue_cmd(CMD_CLEAR, any_node(), any_node(), pick_length());
      else if (r <= 3) queue_cmd(CMD_EDGE, any_node(), any_node(), pick_length());
      else if (r <= 5) queue_cmd(CMD_RUN, any_node(), any_node(), pick_length());
      else queue_cmd(CMD_READ, any_node(), any_node(), pick_length());
    end
  endfunction

  // Wait until every queued command has been answered, then let the unit go idle.
  task automatic settle_unit();
    while (pending_cmds.size() != 0 || start || expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [COUNT_BITS-1:0] value);
    repeat ($urandom_range(0, 3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    node_limit = value;
  endtask

  initial begin : stimulus
    int cnt;
    int span;
    clear_routes();
    node_limit = NODE_COUNT_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, overwrite, saturation, diagonal and clear, at the reset node count.
    queue_cmd(CMD_READ, 6'd0, 6'd0, 24'h000000);
    queue_cmd(CMD_EDGE, 6'd0, 6'd1, 24'h000010);
    queue_cmd(CMD_EDGE, 6'd1, 6'd2, 24'h000020);
    queue_cmd(CMD_EDGE, 6'd2, 6'd63, 24'hFFFFFE);
    queue_cmd(CMD_EDGE, 6'd3, 6'd3, 24'h000000);
    queue_cmd(CMD_EDGE, 6'd4, 6'd5, 24'hFFFFFF);
    queue_cmd(CMD_EDGE, 6'd5, 6'd6, 24'h7FFFFF);
    queue_cmd(CMD_EDGE, 6'd6, 6'd7, 24'h800000);
    queue_cmd(CMD_EDGE, 6'd1, 6'd0, 24'h000008);
    queue_cmd(CMD_EDGE, 6'd62, 6'd63, 24'h555555);
    queue_cmd(CMD_EDGE, 6'd20, 6'd21, 24'hAAAAAA);
    queue_cmd(CMD_RUN, 6'd63, 6'd63, 24'hFFFFFF);
    queue_cmd(CMD_READ, 6'd0, 6'd2, 24'hFFFFFF);
    queue_cmd(CMD_READ, 6'd2, 6'd0, 24'h000000);
    queue_cmd(CMD_READ, 6'd0, 6'd0, 24'h000000);
    queue_cmd(CMD_READ, 6'd3, 6'd3, 24'h000000);
    queue_cmd(CMD_READ, 6'd5, 6'd7, 24'h000000);
    queue_cmd(CMD_READ, 6'd0, 6'd63, 24'h000000);
    queue_cmd(CMD_READ, 6'd4, 6'd5, 24'h000000);
    queue_cmd(CMD_READ, 6'd63, 6'd62, 24'h000000);
    queue_cmd(CMD_READ, 6'd21, 6'd20, 24'h000000);
    queue_cmd(CMD_CLEAR, 6'd0, 6'd0, 24'h000000);
    queue_cmd(CMD_READ, 6'd0, 6'd1, 24'h000000);
    settle_unit();

    // Count above the store size must clip to the full table.
    write_node_count(7'd127);
    queue_well_formed(MAX_NODES_DEF, 12);
    queue_cmd(CMD_EDGE, 6'd62, 6'd63, 24'h000001);
    queue_cmd(CMD_RUN, 6'd0, 6'd0, 24'h000000);
    queue_cmd(CMD_READ, 6'd63, 6'd62, 24'h000000);
    settle_unit();

    // Zero count: relaxation must leave the table alone.
    write_node_count(7'd0);
    queue_cmd(CMD_EDGE, 6'd0, 6'd1, 24'h000010);
    queue_cmd(CMD_EDGE, 6'd1, 6'd2, 24'h000010);
    queue_cmd(CMD_RUN, 6'd0, 6'd0, 24'h000000);
    queue_cmd(CMD_READ, 6'd0, 6'd2, 24'h000000);
    queue_cmd(CMD_READ, 6'd1, 6'd0, 24'h000000);

    while (cmds_queued < TARGET_CMDS) begin
      settle_unit();
      cnt = $urandom_range(0, 19);
      if (cnt == 0) cnt = 0;
      else if (cnt == 1) cnt = 1;
      else if (cnt <= 3) cnt = $urandom_range(9, 16);
      else cnt = $urandom_range(2, 8);
      write_node_count(COUNT_BITS'(cnt));
      span = (cnt == 0) ? 8 : cnt;
      if ($urandom_range(0, 6) == 0) queue_noise();
      else queue_well_formed(span, (span < 12) ? span : 12);
    end

    settle_unit();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("all_pairs_shortest_path_unit verification clean");
    end else begin
      $display("all_pairs_shortest_path_unit verification failed");
    end
    $finish;
  end

endmodule

>>> all_pairs_shortest_path_unit.f
+incdir+sv
sv/apsp_pkg.sv
sv/apsp_ctrl.sv
sv/apsp_datapath.sv
sv/all_pairs_shortest_path_unit.sv
sv/apsp_checker.sv
tb/tb_all_pairs_shortest_path_unit.sv
